### rtl/gfa_pkg.sv
// Shared types, constants and helper functions of the Gabor atom generator.
package gfa_pkg;

  typedef enum logic {
    OP_PRIMAL = 1'b0,
    OP_DUAL   = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_e;

  typedef enum logic [2:0] {
    REG_SHIFT_STEP    = 3'd0,
    REG_SHIFT_RECIP   = 3'd1,
    REG_SHIFT_INVROOT = 3'd2,
    REG_FREQ_STEP     = 3'd3
  } reg_idx_e;

  typedef struct packed {
    opcode_e            opcode;
    logic signed [15:0] freq_index;
    logic signed [15:0] time_index;
    logic signed [31:0] sample_time;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] value_real;
    logic signed [31:0] value_imag;
  } out_word_t;

  typedef struct packed {
    logic [31:0] shift_step;
    logic [31:0] shift_step_recip;
    logic [31:0] shift_step_inv_root;
    logic [31:0] freq_step;
  } cfg_t;

  localparam int          CORDIC_STEPS = 30;
  localparam int          CW           = 34;
  localparam logic [31:0] ONE_Q16      = 32'd65536;
  localparam logic [31:0] RESET_VAL    = 32'd65536;
  localparam logic [CW-1:0] CORDIC_X0  = 34'h026DD3B6A;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    quad_e                quad;
    logic [47:0]          amp;
  } cord_t;

  function automatic logic [31:0] atan_turn(input int step);
    logic [31:0] t [CORDIC_STEPS];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
          32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
          32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
          32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
          32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
          32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
    return t[step];
  endfunction

  // hat(u): u on [0,1), 2-u on [1,2), 0 elsewhere
  function automatic logic [16:0] hat(input logic signed [42:0] u);
    logic signed [42:0] two;
    logic signed [42:0] r;
    two = 43'sd131072;
    r = two - u;
    if (u >= 43'sd0 && u < 43'sd65536) return u[16:0];
    if (u >= 43'sd65536 && u < 43'sd131072) return r[16:0];
    return 17'd0;
  endfunction

  // round Q4.30 to Q2.16 and clamp to [-1, 1]
  function automatic logic signed [17:0] clamp_unit(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + 34'sd8192) >>> 14;
    if (r > 34'sd65536) return 18'sd65536;
    if (r < -34'sd65536) return -18'sd65536;
    return r[17:0];
  endfunction

endpackage

### rtl/gabor_frame_atom_generator_core.sv
// Top level of the Gabor frame atom generator with hat window.
// Takes one word per cycle while not stalled and returns one result word per input
// word, in order: a front pipeline forms the window amplitude and phase, thirty CORDIC
// cells in a row turn the phase into cos and sin, and the last stages fold, scale and
// register the result. A skid register behind the output takes one more result while
// the output is stalled; only once it is full do the pipeline hold and the input stall.
// Registers reset to 1.0. Write them only while no word is in flight (not enforced).
module gabor_frame_atom_generator_core import gfa_pkg::*; #(
  parameter int PHASE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t      cfg_q;
  logic      en;
  logic      chain_v [CORDIC_STEPS+1];
  cord_t     chain_d [CORDIC_STEPS+1];
  logic      back_v;
  out_word_t back_w;
  logic      skid_v_q;
  out_word_t skid_w_q;

  assign en          = !skid_v_q;
  assign in_stall_o  = skid_v_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shift_step          <= RESET_VAL;
      cfg_q.shift_step_recip    <= RESET_VAL;
      cfg_q.shift_step_inv_root <= RESET_VAL;
      cfg_q.freq_step           <= RESET_VAL;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SHIFT_STEP:    cfg_q.shift_step          <= cfg_data_i;
        REG_SHIFT_RECIP:   cfg_q.shift_step_recip    <= cfg_data_i;
        REG_SHIFT_INVROOT: cfg_q.shift_step_inv_root <= cfg_data_i;
        REG_FREQ_STEP:     cfg_q.freq_step           <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gfa_front #(.PHASE_BITS(PHASE_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .word_i  (in_word_i),
    .valid_o (chain_v[0]),
    .cord_o  (chain_d[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    gfa_cordic_cell #(.STEP(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_v[i]),
      .cord_i  (chain_d[i]),
      .valid_o (chain_v[i+1]),
      .cord_o  (chain_d[i+1])
    );
  end

  gfa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_v[CORDIC_STEPS]),
    .cord_i  (chain_d[CORDIC_STEPS]),
    .valid_o (back_v),
    .word_o  (back_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      skid_v_q    <= 1'b0;
    end else if (!out_valid_o || !out_stall_i) begin
      out_valid_o <= skid_v_q || back_v;
      skid_v_q    <= 1'b0;
    end else if (en && back_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_o || !out_stall_i) begin
      out_word_o <= skid_v_q ? skid_w_q : back_w;
    end else if (en) begin
      skid_w_q <= back_w;
    end
  end

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stall without a held result");

  a_chain_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> ($stable(chain_v[CORDIC_STEPS]) && $stable(back_v)))
    else $error("pipeline moved while skid register full");

  a_held_word_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled output word changed");

endmodule

### rtl/gfa_front.sv
// Window amplitude and phase pipeline ahead of the CORDIC chain.
module gfa_front import gfa_pkg::*; #(
  parameter int PHASE_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  cfg_t     cfg_i,
  input  logic     valid_i,
  input  in_word_t word_i,
  output logic     valid_o,
  output cord_t    cord_o
);

  localparam int PB = PHASE_BITS;

  logic [7:0] v_q;

  logic signed [48:0] ka_d, ka_q, hbf;
  logic [31:0]        hb_q;
  logic signed [31:0] x_q;
  opcode_e            op0_q, op1_q, op2_q, op3_q, op4_q;

  logic signed [49:0] d;
  logic [49:0]        absd_d, absd_q;
  logic               neg1_q, neg2_q;
  logic [63:0]        pp;
  logic [PB-1:0]      ph1_q, ph2_q, ph3_q, ph4_q, ph5_q, ph6_q, ph7_q;

  logic [63:0]        pl_q;
  logic [49:0]        ph_q;

  logic [65:0]        t3;
  logic [40:0]        um;
  logic signed [42:0] u;
  logic [16:0]        h0, h1;
  logic [17:0]        sum, sel3_q, sel4_q;

  logic [63:0]        abq_full;
  logic [47:0]        abq_q;
  logic [49:0]        dlo_q;
  logic [33:0]        dhi_q;

  logic [65:0]        t5;
  logic [49:0]        t5s;
  logic [47:0]        w_d, w_q;

  logic [63:0]        alo_q;
  logic [47:0]        ahi_q;
  logic [79:0]        t7;
  logic [63:0]        t7s;
  logic [47:0]        amp_d, amp_q;

  assign ka_d   = $signed(word_i.time_index) * $signed({1'b0, cfg_i.shift_step});
  assign hbf    = $signed(word_i.freq_index) * $signed({1'b0, cfg_i.freq_step});
  assign d      = {{18{x_q[31]}}, x_q} - {ka_q[48], ka_q};
  assign absd_d = d[49] ? 50'(-d) : 50'(d);
  assign pp     = hb_q * x_q;

  assign t3  = {ph_q, 16'd0} + 66'(pl_q >> 16);
  assign um  = (ph_q >= 50'h0800000000000 || t3 > 66'h10000000000) ? 41'h10000000000
                                                                  : t3[40:0];
  assign u   = neg2_q ? -$signed({2'b00, um}) : $signed({2'b00, um});
  assign h0  = hat(u);
  assign h1  = hat(u + 43'sd65536);
  assign sum = 18'(h0) + {h1, 1'b0};

  assign abq_full = cfg_i.shift_step * cfg_i.freq_step;

  assign t5  = {dhi_q, 32'd0} + 66'(dlo_q);
  assign t5s = t5[65:16];
  assign w_d = (op4_q == OP_DUAL) ? ((t5s > 50'h0800000000000) ? 48'h800000000000
                                                                : t5s[47:0])
                                  : 48'(sel4_q);

  assign t7    = {ahi_q, 32'd0} + 80'(alo_q);
  assign t7s   = t7[79:16];
  assign amp_d = (t7s > 64'h0000800000000000) ? 48'h800000000000 : t7s[47:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    abq_q <= abq_full[63:16];
    if (en_i) begin
      ka_q   <= ka_d;
      hb_q   <= hbf[31:0];
      x_q    <= word_i.sample_time;
      op0_q  <= word_i.opcode;

      absd_q <= absd_d;
      neg1_q <= d[49];
      ph1_q  <= pp[31:32-PB];
      op1_q  <= op0_q;

      pl_q   <= absd_q[31:0] * cfg_i.shift_step_recip;
      ph_q   <= absd_q[49:32] * cfg_i.shift_step_recip;
      neg2_q <= neg1_q;
      ph2_q  <= ph1_q;
      op2_q  <= op1_q;

      sel3_q <= (op2_q == OP_DUAL) ? sum : 18'(h0);
      ph3_q  <= ph2_q;
      op3_q  <= op2_q;

      dlo_q  <= abq_q[31:0] * sel3_q;
      dhi_q  <= abq_q[47:32] * sel3_q;
      sel4_q <= sel3_q;
      ph4_q  <= ph3_q;
      op4_q  <= op3_q;

      w_q    <= w_d;
      ph5_q  <= ph4_q;

      alo_q  <= w_q[31:0] * cfg_i.shift_step_inv_root;
      ahi_q  <= w_q[47:32] * cfg_i.shift_step_inv_root;
      ph6_q  <= ph5_q;

      amp_q  <= amp_d;
      ph7_q  <= ph6_q;
    end
  end

  assign valid_o     = v_q[7];
  assign cord_o.x    = CORDIC_X0;
  assign cord_o.y    = '0;
  assign cord_o.z    = CW'(ph7_q[PB-3:0]) << (32 - PB);
  assign cord_o.quad = quad_e'(ph7_q[PB-1:PB-2]);
  assign cord_o.amp  = amp_q;

endmodule

### rtl/gfa_cordic_cell.sv
// One rotation step of the CORDIC chain.
module gfa_cordic_cell import gfa_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  cord_t cord_i,
  output logic  valid_o,
  output cord_t cord_o
);

  localparam logic signed [CW-1:0] ATAN = $signed(CW'(atan_turn(STEP)));

  logic signed [CW-1:0] xs, ys;
  cord_t                nxt;

  assign xs = cord_i.x >>> STEP;
  assign ys = cord_i.y >>> STEP;

  always_comb begin
    nxt = cord_i;
    if (!cord_i.z[CW-1]) begin
      nxt.x = cord_i.x - ys;
      nxt.y = cord_i.y + xs;
      nxt.z = cord_i.z - ATAN;
    end else begin
      nxt.x = cord_i.x + ys;
      nxt.y = cord_i.y - xs;
      nxt.z = cord_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cord_o <= nxt;
    end
  end

endmodule

### rtl/gfa_back.sv
// Quadrant fold, rounding and output scaling with saturation.
module gfa_back import gfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  cord_t     cord_i,
  output logic      valid_o,
  output out_word_t word_o
);

  logic [1:0]         v_q;
  logic signed [17:0] cc, ss, c_d, s_d, c_q, s_q;
  logic [47:0]        amp_q;
  logic [16:0]        mc, ms;
  logic [48:0]        clo_q, slo_q;
  logic [32:0]        chi_q, shi_q;
  logic               cneg_q, sneg_q;

  assign cc = clamp_unit(cord_i.x);
  assign ss = clamp_unit(cord_i.y);

  always_comb begin
    case (cord_i.quad)
      QUAD_I:   begin c_d = cc;  s_d = ss;  end
      QUAD_II:  begin c_d = -ss; s_d = cc;  end
      QUAD_III: begin c_d = -cc; s_d = -ss; end
      QUAD_IV:  begin c_d = ss;  s_d = -cc; end
      default:  begin c_d = cc;  s_d = ss;  end
    endcase
  end

  assign mc = c_q[17] ? 17'(-c_q) : c_q[16:0];
  assign ms = s_q[17] ? 17'(-s_q) : s_q[16:0];

  function automatic logic [31:0] scale(input logic [32:0] hi, input logic [48:0] lo,
                                        input logic neg);
    logic [64:0] t;
    logic [48:0] m;
    logic [31:0] mag;
    t   = {hi, 32'd0} + 65'(lo);
    m   = t[64:16];
    mag = (m > 49'h80000000) ? 32'h80000000 : m[31:0];
    if (neg) return 32'(-mag);
    return (mag > 32'h7FFFFFFF) ? 32'h7FFFFFFF : mag;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q    <= c_d;
      s_q    <= s_d;
      amp_q  <= cord_i.amp;
      clo_q  <= amp_q[31:0] * mc;
      chi_q  <= amp_q[47:32] * mc;
      slo_q  <= amp_q[31:0] * ms;
      shi_q  <= amp_q[47:32] * ms;
      cneg_q <= c_q[17];
      sneg_q <= s_q[17];
    end
  end

  assign valid_o           = v_q[1];
  assign word_o.value_real = scale(chi_q, clo_q, cneg_q);
  assign word_o.value_imag = scale(shi_q, slo_q, sneg_q);

endmodule

### tb/sv/tb_top.sv
// Testbench for the Gabor frame atom generator core: table and random words, checked by table or predictor.
`timescale 1ns / 1ps
module tb_top;
  import gfa_pkg::*;

  localparam int PHASE_W = 16;
  localparam int WATCHDOG = 4000;
  localparam logic [2:0] REG_NONE = 3'd7;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] TURN_TBL [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  logic [31:0] step_a, recip_a, inv_root_a, step_b;
  out_word_t   pending_atoms[$];
  bit          failed = 1'b0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  gabor_frame_atom_generator_core #(.PHASE_BITS(PHASE_W)) u_top (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] q16_mul_sat(logic [63:0] p, logic [31:0] q,
                                              logic [63:0] lim);
    logic [63:0] hi, t;
    hi = (p >> 32) * {32'b0, q};
    if (hi >= 64'h0000_8000_0000_0000) return lim;
    t = (hi << 16) + (({32'b0, p[31:0]} * {32'b0, q}) >> 16);
    return (t > lim) ? lim : t;
  endfunction

  function automatic longint hat_q16(longint u);
    if (u >= 0 && u < 65536) return u;
    if (u >= 65536 && u < 131072) return 131072 - u;
    return 0;
  endfunction

  function automatic longint round_unit(longint v);
    longint r;
    r = (v + 8192) >>> 14;
    if (r > 65536) return 65536;
    if (r < -65536) return -65536;
    return r;
  endfunction

  function automatic logic [31:0] scaled_part(logic [63:0] amp, longint c);
    logic [63:0] mag;
    logic [63:0] neg;
    mag = q16_mul_sat(amp, (c < 0) ? 32'(-c) : 32'(c), 64'h8000_0000);
    if (c < 0) begin
      neg = 64'd0 - mag;
      return neg[31:0];
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  function automatic out_word_t predict_atom(in_word_t w);
    longint d, u, hb, prod, cx, cy, cz, nx, cc, ss, c, s;
    logic [63:0] um, wv, amp, abq;
    logic [31:0] ph, sum;
    out_word_t r;
    d = longint'(w.sample_time) - longint'(w.time_index) * longint'({32'b0, step_a});
    um = q16_mul_sat((d < 0) ? -d : d, recip_a, 64'd1 << 40);
    u = (d < 0) ? -longint'(um) : longint'(um);
    if (w.opcode == OP_DUAL) begin
      abq = ({32'b0, step_a} * {32'b0, step_b}) >> 16;
      sum = 32'(hat_q16(u) + 2 * hat_q16(u + 65536));
      wv = q16_mul_sat(abq, sum, 64'd1 << 47);
    end else begin
      wv = hat_q16(u);
    end
    amp = q16_mul_sat(wv, inv_root_a, 64'd1 << 47);
    hb = longint'(w.freq_index) * longint'({32'b0, step_b});
    prod = hb * longint'(w.sample_time);
    ph = prod[31:0];
    ph = (ph >> (32 - PHASE_W)) << (32 - PHASE_W);
    cx = 64'h26DD3B6A;
    cy = 0;
    cz = longint'({34'b0, ph[29:0]});
    for (int i = 0; i < 30; i++) begin
      if (cz >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        cz = cz - longint'({32'b0, TURN_TBL[i]});
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        cz = cz + longint'({32'b0, TURN_TBL[i]});
      end
      cx = nx;
    end
    cc = round_unit(cx);
    ss = round_unit(cy);
    case (quad_e'(ph[31:30]))
      QUAD_I:   begin c = cc;  s = ss;  end
      QUAD_II:  begin c = -ss; s = cc;  end
      QUAD_III: begin c = -cc; s = -ss; end
      default:  begin c = ss;  s = -cc; end
    endcase
    r.value_real = scaled_part(amp, c);
    r.value_imag = scaled_part(amp, s);
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    bit took;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    case (idx)
      REG_SHIFT_STEP:    step_a = val;
      REG_SHIFT_RECIP:   recip_a = val;
      REG_SHIFT_INVROOT: inv_root_a = val;
      REG_FREQ_STEP:     step_b = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] a, logic [31:0] ra, logic [31:0] ia,
                          logic [31:0] b);
    while (pending_atoms.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    write_reg(REG_SHIFT_STEP, a);
    write_reg(REG_SHIFT_RECIP, ra);
    write_reg(REG_NONE, $urandom);
    write_reg(REG_SHIFT_INVROOT, ia);
    write_reg(REG_FREQ_STEP, b);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(in_word_t w, bit typed, out_word_t res);
    bit took;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      if (took) pending_atoms.push_back(typed ? res : predict_atom(w));
      @(posedge clk_i);
    end while (!took);
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    longint dd, xx;
    w.opcode = opcode_e'($urandom_range(0, 1));
    w.freq_index = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16) - 8);
    w.time_index = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64) - 32);
    w.sample_time = $urandom;
    if ($urandom_range(0, 9) < 7) begin
      dd = ((longint'({32'b0, step_a}) * longint'($urandom_range(0, 262143))) >>> 16)
           - longint'({32'b0, step_a});
      xx = longint'(w.time_index) * longint'({32'b0, step_a}) + dd;
      if (xx >= -64'sd2147483648 && xx <= 64'sd2147483647) w.sample_time = 32'(xx);
    end
    return w;
  endfunction

  always @(posedge clk_i) out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);

  always @(negedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("gabor_frame_atom_generator_core: mismatch");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_atoms.size() == 0) begin
          $error("unexpected word: value_real %0d value_imag %0d",
                 out_word_o.value_real, out_word_o.value_imag);
          failed = 1'b1;
        end else begin
          exp_w = pending_atoms.pop_front();
          if (out_word_o.value_real !== exp_w.value_real) begin
            $error("value_real: expected %0d, got %0d", exp_w.value_real,
                   out_word_o.value_real);
            failed = 1'b1;
          end
          if (out_word_o.value_imag !== exp_w.value_imag) begin
            $error("value_imag: expected %0d, got %0d", exp_w.value_imag,
                   out_word_o.value_imag);
            failed = 1'b1;
          end
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    int mode;
    logic [31:0] a;
    step_a = RESET_VAL;
    recip_a = RESET_VAL;
    inv_root_a = RESET_VAL;
    step_b = RESET_VAL;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero-result rows: origin, outside the hat, left of the dual support
    r = '{w: '{OP_PRIMAL, 16'sd0, 16'sd0, 32'sd0}, typed: 1, res: '0}; rows.push_back(r);
    r = '{w: '{OP_PRIMAL, 16'sd3, 16'sd0, 32'sh5_0000}, typed: 1, res: '0}; rows.push_back(r);
    r = '{w: '{OP_DUAL, 16'sd3, 16'sd0, 32'sh5_0000}, typed: 1, res: '0}; rows.push_back(r);
    r = '{w: '{OP_DUAL, 16'sd1, 16'sd0, -32'sh1_0000}, typed: 1, res: '0}; rows.push_back(r);
    r = '{w: '{OP_PRIMAL, 16'sd1, 16'sd0, -32'sh1_0000}, typed: 1, res: '0}; rows.push_back(r);
    r.typed = 0;
    r.w = '{OP_PRIMAL, 16'sd0, 16'sd0, 32'sh8000};  rows.push_back(r);
    r.w = '{OP_PRIMAL, 16'sd1, 16'sd0, 32'sh4000};  rows.push_back(r);
    r.w = '{OP_PRIMAL, 16'sd1, 16'sd0, 32'shC000};  rows.push_back(r);
    r.w = '{OP_PRIMAL, 16'sd1, 16'sd0, 32'sh1_8000}; rows.push_back(r);
    r.w = '{OP_PRIMAL, -16'sd1, 16'sd1, 32'sh1_4000}; rows.push_back(r);
    r.w = '{OP_DUAL, 16'sd1, 16'sd0, -32'sh8000};   rows.push_back(r);
    r.w = '{OP_DUAL, 16'sd2, 16'sd0, 32'sh1_2000};  rows.push_back(r);
    r.w = '{OP_DUAL, -16'sd32768, 16'sd32767, 32'sh7FFF_FFFF}; rows.push_back(r);
    r.w = '{OP_PRIMAL, 16'sd32767, -16'sd32768, -32'sh8000_0000}; rows.push_back(r);
    r.w = '{OP_DUAL, 16'sd32767, 16'sd32767, 32'sh7FFF_0000}; rows.push_back(r);
    r.w = '{OP_PRIMAL, -16'sd32768, -16'sd32768, -32'sh7FFF_8000}; rows.push_back(r);
    r.w = '{OP_DUAL, -16'sd1, -16'sd1, -32'sh1}; rows.push_back(r);
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);

    for (int ph = 0; ph < 8; ph++) begin
      mode = ph % 4;
      in_valid_i <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      case (ph)
        0: set_regs(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        1: set_regs(32'd1, 32'd1, 32'd1, 32'd1);
        2: set_regs(32'h0001_0000, ALL_ONES, 32'h0100_0000, 32'd1);
        3: set_regs(ALL_ONES, 32'd1, 32'h0002_0000, 32'h8000_0000);
        default: begin
          a = $urandom_range(32'h4000, 32'h4_0000);
          set_regs(a, 32'(64'h1_0000_0000 / a),
                   32'($rtoi(65536.0 / $sqrt(real'(a) / 65536.0))),
                   $urandom_range(1, 32'h2_0000));
        end
      endcase
      send_idle_pct = (mode == 1) ? 51 : (mode == 3) ? 30 : 0;
      recv_stall_pct = (mode == 2) ? 51 : (mode == 3) ? 30 : 0;
      for (int n = 0; n < 105; n++) begin
        if (n == 70) begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        send_word(random_word(), 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;
    while (pending_atoms.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (!failed)
      $display("gabor_frame_atom_generator_core: match");
    else
      $display("gabor_frame_atom_generator_core: mismatch");
    $finish;
  end
endmodule
